/* src/differential_drive_odometry_unit_defines.svh */
// Assertion macros shared by the odometry unit.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH

`ifndef SYNTH
`define DDO_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("odometry check failed");
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odometry check failed");
`else
`define DDO_ASSERT_SAME(label, clk, rst, ante, cons)
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/ddo_pkg.sv */
`default_nettype none

package ddo_pkg;

   localparam logic [15:0] RATE_DIVISOR  = 16'd1000;
   localparam logic [15:0] ANGLE_DIVISOR = 16'd125;
   localparam logic [15:0] SPACING_RESET = 16'd2560;

   localparam int DIV_W      = 50;
   localparam int DIV_CYCLES = 25;

   localparam longint PI_Q      = 64'sd1686629713;
   localparam longint TWO_PI_Q  = 64'sd3373259426;
   localparam longint HALF_PI_Q = 64'sd843314856;
   localparam longint GAIN_Q    = 64'sd326016437;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_LIN,
      OP_DIV_ANG,
      OP_DIV_HEAD,
      OP_DIV_DIST,
      OP_SAVE_LIN,
      OP_SAVE_ANG,
      OP_SAVE_HEAD,
      OP_SAVE_DIST,
      OP_MUL_HEAD,
      OP_MUL_DIST,
      OP_ROT_START,
      OP_MUL_XLO,
      OP_MUL_XHI,
      OP_ADD_X,
      OP_MUL_YLO,
      OP_MUL_YHI,
      OP_ADD_Y,
      OP_EMIT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LIN_START,
      ST_LIN_RUN,
      ST_ANG_START,
      ST_ANG_RUN,
      ST_HEAD_MUL,
      ST_HEAD_START,
      ST_HEAD_RUN,
      ST_DIST_MUL,
      ST_DIST_START,
      ST_DIST_RUN,
      ST_ROT_START,
      ST_ROT_RUN,
      ST_X_HI,
      ST_X_ADD,
      ST_Y_LO,
      ST_Y_HI,
      ST_Y_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic rot_busy;
   } status_type;

   // atan(2^-i) in units of 2^-29 rad.
   function automatic logic [28:0] atan_q29(input logic [4:0] idx);
      logic [28:0] val;
      case (idx)
         5'd0:    val = 29'd421657428;
         5'd1:    val = 29'd248918915;
         5'd2:    val = 29'd131521918;
         5'd3:    val = 29'd66762579;
         5'd4:    val = 29'd33510843;
         5'd5:    val = 29'd16771758;
         5'd6:    val = 29'd8387925;
         5'd7:    val = 29'd4194219;
         5'd8:    val = 29'd2097141;
         5'd9:    val = 29'd1048575;
         5'd10:   val = 29'd524288;
         5'd11:   val = 29'd262144;
         5'd12:   val = 29'd131072;
         5'd13:   val = 29'd65536;
         5'd14:   val = 29'd32768;
         5'd15:   val = 29'd16384;
         5'd16:   val = 29'd8192;
         5'd17:   val = 29'd4096;
         5'd18:   val = 29'd2048;
         5'd19:   val = 29'd1024;
         5'd20:   val = 29'd512;
         5'd21:   val = 29'd256;
         5'd22:   val = 29'd128;
         5'd23:   val = 29'd64;
         5'd24:   val = 29'd32;
         5'd25:   val = 29'd16;
         5'd26:   val = 29'd8;
         5'd27:   val = 29'd4;
         5'd28:   val = 29'd2;
         5'd29:   val = 29'd1;
         5'd30:   val = 29'd1;
         default: val = 29'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* src/ddo_ctrl.sv */
`default_nettype none

module ddo_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output ddo_pkg::cmd_type        cmd,
   input  wire ddo_pkg::status_type status
);
   import ddo_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      emit_ok;

   assign emit_ok = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_tvalid) state_in = ST_LIN_START;
         ST_LIN_START:  state_in = ST_LIN_RUN;
         ST_LIN_RUN:    if (!status.div_busy) state_in = ST_ANG_START;
         ST_ANG_START:  state_in = ST_ANG_RUN;
         ST_ANG_RUN:    if (!status.div_busy) state_in = ST_HEAD_MUL;
         ST_HEAD_MUL:   state_in = ST_HEAD_START;
         ST_HEAD_START: state_in = ST_HEAD_RUN;
         ST_HEAD_RUN:   if (!status.div_busy) state_in = ST_DIST_MUL;
         ST_DIST_MUL:   state_in = ST_DIST_START;
         ST_DIST_START: state_in = ST_DIST_RUN;
         ST_DIST_RUN:   if (!status.div_busy) state_in = ST_ROT_START;
         ST_ROT_START:  state_in = ST_ROT_RUN;
         ST_ROT_RUN:    if (!status.rot_busy) state_in = ST_X_HI;
         ST_X_HI:       state_in = ST_X_ADD;
         ST_X_ADD:      state_in = ST_Y_LO;
         ST_Y_LO:       state_in = ST_Y_HI;
         ST_Y_HI:       state_in = ST_Y_ADD;
         ST_Y_ADD:      state_in = ST_EMIT;
         ST_EMIT:       if (emit_ok) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_LOAD;
         end
         ST_LIN_START:  cmd.op = OP_DIV_LIN;
         ST_LIN_RUN:    if (!status.div_busy) cmd.op = OP_SAVE_LIN;
         ST_ANG_START:  cmd.op = OP_DIV_ANG;
         ST_ANG_RUN:    if (!status.div_busy) cmd.op = OP_SAVE_ANG;
         ST_HEAD_MUL:   cmd.op = OP_MUL_HEAD;
         ST_HEAD_START: cmd.op = OP_DIV_HEAD;
         ST_HEAD_RUN:   if (!status.div_busy) cmd.op = OP_SAVE_HEAD;
         ST_DIST_MUL:   cmd.op = OP_MUL_DIST;
         ST_DIST_START: cmd.op = OP_DIV_DIST;
         ST_DIST_RUN:   if (!status.div_busy) cmd.op = OP_SAVE_DIST;
         ST_ROT_START:  cmd.op = OP_ROT_START;
         ST_ROT_RUN:    if (!status.rot_busy) cmd.op = OP_MUL_XLO;
         ST_X_HI:       cmd.op = OP_MUL_XHI;
         ST_X_ADD:      cmd.op = OP_ADD_X;
         ST_Y_LO:       cmd.op = OP_MUL_YLO;
         ST_Y_HI:       cmd.op = OP_MUL_YHI;
         ST_Y_ADD:      cmd.op = OP_ADD_Y;
         ST_EMIT:       if (emit_ok) cmd.op = OP_EMIT;
         default:       cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

/* src/ddo_datapath.sv */
`default_nettype none

module ddo_datapath #(
   parameter int CORDIC_STEPS = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [15:0]         csr_wr_data,
   input  wire logic [63:0]         req_tdata,
   input  wire ddo_pkg::cmd_type    cmd,
   output ddo_pkg::status_type      status,
   output logic [175:0]             rsp_tdata
);
   import ddo_pkg::*;

   localparam int RCW = $clog2(CORDIC_STEPS + 1);

   localparam logic signed [51:0] PI_W      = 52'(PI_Q);
   localparam logic signed [51:0] TWO_PI_W  = 52'(TWO_PI_Q);
   localparam logic signed [33:0] PI_R      = 34'(PI_Q);
   localparam logic signed [33:0] HALF_PI_R = 34'(HALF_PI_Q);
   localparam logic signed [33:0] GAIN_R    = 34'(GAIN_Q);
   localparam logic signed [51:0] S32_MAX   = 52'sd2147483647;
   localparam logic signed [51:0] S32_MIN   = -52'sd2147483648;
   localparam logic signed [43:0] S40_MAX   = 44'sd549755813887;
   localparam logic signed [43:0] S40_MIN   = -44'sd549755813888;

   function automatic logic signed [31:0] sat_mag32(input logic [DIV_W-1:0] mag,
                                                    input logic neg);
      logic signed [31:0] res;
      if (!neg) begin
         res = (mag > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
      end else begin
         res = (mag > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(32'd0 - mag[31:0]);
      end
      return res;
   endfunction

   // Input beat and configuration.
   logic [15:0]        dt_ff;
   logic signed [23:0] left_ff, right_ff;
   logic [15:0]        spacing_ff;

   // Results and kept state.
   logic signed [31:0] lin_ff, ang_ff, head_ff;
   logic signed [39:0] pos_x_ff, pos_y_ff;
   logic [37:0]        dist_mag_ff;
   logic               dist_neg_ff;
   logic [63:0]        prod_ff;
   logic               prod_neg_ff;
   logic [33:0]        acc_ff;
   logic [175:0]       out_ff;

   // Divider.
   logic [DIV_W-1:0] div_num_ff, div_num_in;
   logic [15:0]      div_rem_ff, div_rem_in;
   logic [15:0]      div_den_ff;
   logic             div_neg_ff;
   logic [4:0]       div_cnt_ff;

   // Rotation unit.
   logic signed [33:0] rx_ff, ry_ff, rz_ff;
   logic               flip_ff;
   logic [RCW-1:0]     rot_cnt_ff;

   // Operand selection.
   logic signed [24:0] sum_lr, dif_lr;
   logic [24:0]        sum_mag, dif_mag;
   logic               div_start;
   logic [DIV_W-1:0]   div_mag;
   logic               div_sign;
   logic [15:0]        div_den;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;

   assign sum_lr  = 25'(left_ff) + 25'(right_ff);
   assign dif_lr  = 25'(right_ff) - 25'(left_ff);
   assign sum_mag = sum_lr[24] ? 25'(-sum_lr) : sum_lr;
   assign dif_mag = dif_lr[24] ? 25'(-dif_lr) : dif_lr;

   always_comb begin
      div_start = 1'b1;
      div_mag   = '0;
      div_sign  = 1'b0;
      div_den   = RATE_DIVISOR;
      case (cmd.op)
         OP_DIV_LIN: begin
            div_mag  = {10'b0, sum_mag, 15'b0};
            div_sign = sum_lr[24];
         end
         OP_DIV_ANG: begin
            div_mag  = {5'b0, dif_mag, 20'b0};
            div_sign = dif_lr[24];
            div_den  = (spacing_ff == 16'd0) ? 16'd1 : spacing_ff;
         end
         OP_DIV_HEAD: begin
            div_mag  = {prod_ff[47:0], 2'b0};
            div_sign = prod_neg_ff;
            div_den  = ANGLE_DIVISOR;
         end
         OP_DIV_DIST: begin
            div_mag  = {2'b0, prod_ff[47:0]};
            div_sign = prod_neg_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   // Two restoring steps per cycle; the remainder always stays below the divisor.
   always_comb begin
      logic [16:0] trial;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      for (int k = 0; k < 2; k++) begin
         trial      = {div_rem_in, div_num_in[DIV_W-1]};
         div_num_in = {div_num_in[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, div_den_ff}) begin
            trial         = trial - {1'b0, div_den_ff};
            div_num_in[0] = 1'b1;
         end
         div_rem_in = trial[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (div_start) begin
         div_cnt_ff <= 5'(DIV_CYCLES);
      end else if (div_cnt_ff != 5'd0) begin
         div_cnt_ff <= div_cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         div_num_ff <= div_mag + DIV_W'(div_den >> 1);
         div_rem_ff <= '0;
         div_den_ff <= div_den;
         div_neg_ff <= div_sign;
      end else if (div_cnt_ff != 5'd0) begin
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
      end
   end

   // Heading update with a single wrap by two pi, then saturation to 32 bits.
   logic signed [51:0] head_inc, head_sum, head_wrap, head_sat;

   always_comb begin
      head_inc = div_neg_ff ? -$signed({2'b0, div_num_ff}) : $signed({2'b0, div_num_ff});
      head_sum = 52'(head_ff) + head_inc;
      if (head_sum > PI_W) begin
         head_wrap = head_sum - TWO_PI_W;
      end else if (head_sum < -PI_W) begin
         head_wrap = head_sum + TWO_PI_W;
      end else begin
         head_wrap = head_sum;
      end
      if (head_wrap > S32_MAX) begin
         head_sat = S32_MAX;
      end else if (head_wrap < S32_MIN) begin
         head_sat = S32_MIN;
      end else begin
         head_sat = head_wrap;
      end
   end

   // Rotation step.
   logic [4:0]         rot_idx;
   logic signed [33:0] rot_atan, x_sh, y_sh, h_ext;
   logic signed [33:0] cos_v, sin_v;
   logic [31:0]        cos_mag, sin_mag;

   assign rot_idx  = 5'(RCW'(CORDIC_STEPS) - rot_cnt_ff);
   assign rot_atan = $signed({5'b0, atan_q29(rot_idx)});
   assign x_sh     = rx_ff >>> rot_idx;
   assign y_sh     = ry_ff >>> rot_idx;
   assign h_ext    = 34'(head_ff);
   assign cos_v    = flip_ff ? -rx_ff : rx_ff;
   assign sin_v    = flip_ff ? -ry_ff : ry_ff;
   assign cos_mag  = cos_v[33] ? 32'(-cos_v) : cos_v[31:0];
   assign sin_mag  = sin_v[33] ? 32'(-sin_v) : sin_v[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_cnt_ff <= '0;
      end else if (cmd.op == OP_ROT_START) begin
         rot_cnt_ff <= RCW'(CORDIC_STEPS);
      end else if (rot_cnt_ff != '0) begin
         rot_cnt_ff <= rot_cnt_ff - RCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ROT_START) begin
         rx_ff <= GAIN_R;
         ry_ff <= '0;
         if (h_ext > HALF_PI_R) begin
            rz_ff   <= h_ext - PI_R;
            flip_ff <= 1'b1;
         end else if (h_ext < -HALF_PI_R) begin
            rz_ff   <= h_ext + PI_R;
            flip_ff <= 1'b1;
         end else begin
            rz_ff   <= h_ext;
            flip_ff <= 1'b0;
         end
      end else if (rot_cnt_ff != '0) begin
         if (!rz_ff[33]) begin
            rx_ff <= rx_ff - y_sh;
            ry_ff <= ry_ff + x_sh;
            rz_ff <= rz_ff - rot_atan;
         end else begin
            rx_ff <= rx_ff + y_sh;
            ry_ff <= ry_ff - x_sh;
            rz_ff <= rz_ff + rot_atan;
         end
      end
   end

   // Shared multiplier, operands as magnitudes.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_HEAD: begin
            mul_a = ang_ff[31] ? 32'd0 - ang_ff : ang_ff;
            mul_b = {16'b0, dt_ff};
         end
         OP_MUL_DIST: begin
            mul_a = lin_ff[31] ? 32'd0 - lin_ff : lin_ff;
            mul_b = {16'b0, dt_ff};
         end
         OP_MUL_XLO: begin
            mul_a = dist_mag_ff[31:0];
            mul_b = cos_mag;
         end
         OP_MUL_XHI: begin
            mul_a = {26'b0, dist_mag_ff[37:32]};
            mul_b = cos_mag;
         end
         OP_MUL_YLO: begin
            mul_a = dist_mag_ff[31:0];
            mul_b = sin_mag;
         end
         OP_MUL_YHI: begin
            mul_a = {26'b0, dist_mag_ff[37:32]};
            mul_b = sin_mag;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // Position accumulate: high partial product shifted by three plus the rounded low part.
   logic [41:0]        step_mag;
   logic               step_neg;
   logic signed [43:0] pos_sel, pos_sum, pos_sat;

   assign step_mag = {prod_ff[38:0], 3'b0} + 42'(acc_ff);
   assign step_neg = (cmd.op == OP_ADD_Y) ? (dist_neg_ff ^ sin_v[33])
                                          : (dist_neg_ff ^ cos_v[33]);
   assign pos_sel  = (cmd.op == OP_ADD_Y) ? 44'(pos_y_ff) : 44'(pos_x_ff);

   always_comb begin
      pos_sum = step_neg ? pos_sel - $signed({2'b0, step_mag})
                         : pos_sel + $signed({2'b0, step_mag});
      if (pos_sum > S40_MAX) begin
         pos_sat = S40_MAX;
      end else if (pos_sum < S40_MIN) begin
         pos_sat = S40_MIN;
      end else begin
         pos_sat = pos_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_RESET;
         head_ff    <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
      end else begin
         if (csr_wr_en) spacing_ff <= csr_wr_data;
         if (cmd.op == OP_SAVE_HEAD) head_ff <= head_sat[31:0];
         if (cmd.op == OP_ADD_X) pos_x_ff <= pos_sat[39:0];
         if (cmd.op == OP_ADD_Y) pos_y_ff <= pos_sat[39:0];
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            dt_ff    <= req_tdata[15:0];
            left_ff  <= req_tdata[39:16];
            right_ff <= req_tdata[63:40];
         end
         OP_SAVE_LIN: lin_ff <= sat_mag32(div_num_ff, div_neg_ff);
         OP_SAVE_ANG: ang_ff <= sat_mag32(div_num_ff, div_neg_ff);
         OP_SAVE_DIST: begin
            dist_mag_ff <= div_num_ff[37:0];
            dist_neg_ff <= div_neg_ff;
         end
         OP_MUL_HEAD: begin
            prod_ff     <= mul_p;
            prod_neg_ff <= ang_ff[31];
         end
         OP_MUL_DIST: begin
            prod_ff     <= mul_p;
            prod_neg_ff <= lin_ff[31];
         end
         OP_MUL_XLO, OP_MUL_YLO: prod_ff <= mul_p;
         OP_MUL_XHI, OP_MUL_YHI: begin
            acc_ff  <= 34'((prod_ff + 64'd268435456) >> 29);
            prod_ff <= mul_p;
         end
         OP_EMIT: out_ff <= {ang_ff, lin_ff, head_ff, pos_y_ff, pos_x_ff};
         default: out_ff <= out_ff;
      endcase
   end

   assign status.div_busy = (div_cnt_ff != 5'd0);
   assign status.rot_busy = (rot_cnt_ff != '0);
   assign rsp_tdata       = out_ff;

endmodule

`default_nettype wire

/* src/differential_drive_odometry_unit.sv */
// Channel  | Dir | Ports                          | Contents
// req      | in  | req_tvalid/tready/tdata[63:0]  | step_ms, left, right wheel speed
// rsp      | out | rsp_tvalid/tready/tdata[175:0] | pos_x, pos_y, heading, linear, angular
// csr      | in  | csr_wr_en, csr_wr_data[15:0]   | wheel spacing
//
// Each item runs four passes through the shared 2-bit-per-cycle divider and then the
// rotation loop of one step per cycle (CORDIC_STEPS steps) before its result beat.
// Synchronous active-high reset clears heading and position and sets spacing to 2560.
// A new beat is taken only in idle; the result waits in an output register while
// rsp_tready is low, and the next item may be accepted meanwhile.
`default_nettype none
`include "differential_drive_odometry_unit_defines.svh"

module differential_drive_odometry_unit #(
   parameter int CORDIC_STEPS = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // step_ms[15:0], left_wheel_speed[39:16],
                                          // right_wheel_speed[63:40]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [175:0]      rsp_tdata,   // pos_x[39:0], pos_y[79:40], heading[111:80],
                                          // linear_rate[143:112], angular_rate[175:144]
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data
);
   import ddo_pkg::*;

   cmd_type    cmd;
   status_type status;

   ddo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ddo_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tdata   (rsp_tdata)
   );

   `DDO_ASSERT_SAME(a_idle_units_quiet, clock, reset, req_tready, !status.div_busy && !status.rot_busy)
   `DDO_ASSERT_NEXT(a_emit_sets_valid, clock, reset, cmd.op == OP_EMIT, rsp_tvalid)
   `DDO_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, !req_tready)
   `DDO_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.op == OP_EMIT && rsp_tvalid, rsp_tready)

endmodule

`default_nettype wire

/* tb/differential_drive_odometry_unit_tb.sv */
`timescale 1ns / 100ps

module differential_drive_odometry_unit_tb;
   import ddo_pkg::*;

   localparam int ROT_STEPS  = 24;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_WAIT = 160;
   localparam int RANDOM_PER_PHASE = 90;

   typedef struct {
      logic signed [39:0] pos_x;
      logic signed [39:0] pos_y;
      logic signed [31:0] heading;
      logic signed [31:0] lin_rate;
      logic signed [31:0] ang_rate;
   } pose_type;

   typedef struct {
      logic [15:0]        step_ms;
      logic signed [23:0] left;
      logic signed [23:0] right;
      bit                 typed;
   } drive_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [63:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [175:0] rsp_tdata;
   logic         csr_wr_en;
   logic [15:0]  csr_wr_data;

   longint      spacing_now;
   longint      heading_acc;
   longint      x_acc;
   longint      y_acc;
   longint      atan_q29_tab[ROT_STEPS];
   pose_type    pose_queue[$];
   bit          typed_pending[$];
   int          error_count;
   int          idle_cycles;
   bit          steady;
   bit          hold_rsp;

   differential_drive_odometry_unit #(.CORDIC_STEPS(ROT_STEPS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint round_div(longint num, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // Product over 2^29 with rounding on the magnitude, in 128 bits so no term overflows.
   function automatic longint scale_q29(longint a, longint c);
      logic [127:0] prod;
      longint unsigned am;
      longint unsigned cm;
      am = (a < 0) ? longint'(-a) : longint'(a);
      cm = (c < 0) ? longint'(-c) : longint'(c);
      prod = ({64'd0, am} * {64'd0, cm} + (128'd1 << 28)) >> 29;
      return ((a < 0) != (c < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   // atan(1/n) in Q60 from its alternating power series.
   function automatic longint unsigned atan_recip_q60(longint unsigned n);
      longint unsigned p;
      longint unsigned nn;
      longint unsigned sum;
      longint unsigned k;
      p = (64'd1 << 60) / n;
      nn = n * n;
      sum = 0;
      k = 0;
      while (p != 0) begin
         if (k[0]) sum = sum - p / (2 * k + 1);
         else sum = sum + p / (2 * k + 1);
         p = p / nn;
         k++;
      end
      return sum;
   endfunction

   function automatic void rotate(longint ang, output longint cos_q, output longint sin_q);
      longint x;
      longint y;
      longint z;
      longint nx;
      bit flip;
      x = GAIN_Q;
      y = 0;
      z = ang;
      flip = 1'b0;
      if (z > HALF_PI_Q) begin
         z -= PI_Q;
         flip = 1'b1;
      end else if (z < -HALF_PI_Q) begin
         z += PI_Q;
         flip = 1'b1;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_q29_tab[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_q29_tab[i];
         end
         x = nx;
      end
      cos_q = flip ? -x : x;
      sin_q = flip ? -y : y;
   endfunction

   function automatic pose_type advance_pose(logic [15:0] step_ms, logic signed [23:0] left,
                                             logic signed [23:0] right);
      pose_type p;
      longint dt;
      longint lin;
      longint ang;
      longint h;
      longint travel;
      longint c;
      longint s;
      dt = longint'(step_ms);
      lin = clamp(round_div((longint'(left) + longint'(right)) * 32768, 1000), 32);
      ang = clamp(round_div((longint'(right) - longint'(left)) * 1048576,
                            (spacing_now == 0) ? 1 : spacing_now), 32);
      h = heading_acc + round_div(ang * dt * 4, 125);
      // The heading wraps only once, so a huge step can still leave it saturated.
      if (h > PI_Q) h -= TWO_PI_Q;
      else if (h < -PI_Q) h += TWO_PI_Q;
      heading_acc = clamp(h, 32);
      travel = round_div(lin * dt, 1000);
      rotate(heading_acc, c, s);
      x_acc = clamp(x_acc + scale_q29(travel, c), 40);
      y_acc = clamp(y_acc + scale_q29(travel, s), 40);
      p.pos_x = x_acc[39:0];
      p.pos_y = y_acc[39:0];
      p.heading = heading_acc[31:0];
      p.lin_rate = lin[31:0];
      p.ang_rate = ang[31:0];
      return p;
   endfunction

   task automatic report(string field, logic [39:0] got, logic [39:0] want);
      $display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
      error_count++;
   endtask

   // Acceptance monitor: predicts on each request beat, checks each result beat.
   always @(posedge clock) begin
      pose_type want;
      pose_type row_pose;
      if (!reset && req_tvalid && req_tready) begin
         row_pose = advance_pose(req_tdata[15:0], req_tdata[39:16], req_tdata[63:40]);
         if (typed_pending.size() != 0 && typed_pending.pop_front()) begin
            // Straight out of reset with nothing moving, every field reads zero.
            row_pose = '{default: '0};
         end
         pose_queue.push_back(row_pose);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pose_queue.size() == 0) begin
            $display("%0t: result beat with nothing expected", $time);
            error_count++;
         end else begin
            want = pose_queue.pop_front();
            if (rsp_tdata[39:0] !== want.pos_x) report("pos_x", rsp_tdata[39:0], want.pos_x);
            if (rsp_tdata[79:40] !== want.pos_y) report("pos_y", rsp_tdata[79:40], want.pos_y);
            if (rsp_tdata[111:80] !== want.heading)
               report("heading", 40'(rsp_tdata[111:80]), 40'(want.heading));
            if (rsp_tdata[143:112] !== want.lin_rate)
               report("linear_rate", 40'(rsp_tdata[143:112]), 40'(want.lin_rate));
            if (rsp_tdata[175:144] !== want.ang_rate)
               report("angular_rate", 40'(rsp_tdata[175:144]), 40'(want.ang_rate));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("differential_drive_odometry_unit regression: fail");
            $finish;
         end
      end
   end

   // Result side: random stalls per beat, plus one long hold-off on request.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = steady ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_drive(logic [15:0] step_ms, logic [23:0] left, logic [23:0] right);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {right, left, step_ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic set_spacing(logic [15:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      spacing_now = value;
   endtask

   function automatic logic [23:0] pick_speed(int mode);
      case (mode)
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
         default: return ($urandom_range(0, 1) != 0) ? 24'h7fffff : 24'h800000;
      endcase
   endfunction

   task automatic send_random_drive();
      int mode;
      logic [15:0] step_ms;
      logic [23:0] left;
      logic [23:0] right;
      mode = $urandom_range(0, 3);
      step_ms = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
      left = pick_speed(mode == 3 ? 2 : mode);
      case ($urandom_range(0, 2))
         0: right = left + 24'($urandom_range(0, 512));
         1: right = pick_speed(mode == 3 ? 2 : mode);
         default: right = 24'($urandom);
      endcase
      send_drive(step_ms, left, right);
   endtask

   drive_row_type directed[] = '{
      '{16'd0,     24'sd0,        24'sd0,        1'b1},
      '{16'd1000,  24'sd256000,   24'sd256000,   1'b0},
      '{16'd500,   24'sd0,        24'sd256000,   1'b0},
      '{16'd500,   24'sd0,        24'sd256000,   1'b0},
      '{16'd500,   24'sd0,        24'sd256000,   1'b0},
      '{16'd500,   24'sd0,        24'sd256000,   1'b0},
      '{16'd0,     24'h7fffff,    24'h800000,    1'b0},
      '{16'd65535, 24'h7fffff,    24'h7fffff,    1'b0},
      '{16'd65535, 24'h7fffff,    24'h7fffff,    1'b0},
      '{16'd65535, 24'h7fffff,    24'h7fffff,    1'b0},
      '{16'd65535, 24'h7fffff,    24'h7fffff,    1'b0},
      '{16'd65535, 24'h800000,    24'h800000,    1'b0},
      '{16'd65535, 24'h800000,    24'h7fffff,    1'b0},
      '{16'd65535, 24'h7fffff,    24'h800000,    1'b0},
      '{16'd10,    -24'sd1,       24'sd1,        1'b0},
      '{16'hffff,  24'h555555,    24'haaaaaa,    1'b0}
   };

   logic [15:0] spacing_plan[] = '{16'd65535, 16'd1, 16'd0, 16'd2560, 16'd300, 16'd0};

   initial begin
      longint unsigned s;
      for (int i = 0; i < ROT_STEPS; i++) begin
         if (i == 0) s = atan_recip_q60(2) + atan_recip_q60(3);
         else s = atan_recip_q60(64'd1 << i);
         atan_q29_tab[i] = longint'((s + (64'd1 << 30)) >> 31);
      end
      spacing_now = 2560;
      heading_acc = 0;
      x_acc = 0;
      y_acc = 0;
      error_count = 0;
      steady = 1'b0;
      hold_rsp = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         typed_pending.push_back(directed[i].typed);
         send_drive(directed[i].step_ms, directed[i].left, directed[i].right);
      end

      foreach (spacing_plan[p]) begin
         set_spacing(p == 4 ? 16'($urandom_range(2, 65534)) : spacing_plan[p]);
         steady = (p == 3);
         if (p == 1) hold_rsp = 1'b1;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_drive();
         steady = 1'b0;
      end
      req_tvalid <= 1'b0;

      while (pose_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("differential_drive_odometry_unit regression: pass");
      end else begin
         $display("differential_drive_odometry_unit regression: fail");
      end
      $finish;
   end

endmodule

/* differential_drive_odometry_unit.f */
+incdir+src
src/ddo_pkg.sv
src/ddo_ctrl.sv
src/ddo_datapath.sv
src/differential_drive_odometry_unit.sv
tb/differential_drive_odometry_unit_tb.sv
